>>> hw/rtl/ccfcp_pkg.sv
// shared constants and the cordic arctangent table for the cone center block
// no dependencies

package ccfcp_pkg;

   localparam int COORD_WIDTH_DEF   = 17;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_WIDTH       = 16;
   localparam int CODE_WIDTH        = 3;

   localparam logic [15:0] CONE_RADIUS_RESET  = 16'd154;
   localparam logic [15:0] SLICE_RADIUS_RESET = 16'd102;
   localparam logic [16:0] MAX_WIDTH_RESET    = 17'd512;

   // reject codes
   localparam logic [CODE_WIDTH-1:0] CODE_NONE       = 3'd0;
   localparam logic [CODE_WIDTH-1:0] CODE_OPTIONS    = 3'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_GEOMETRY   = 3'd2;
   localparam logic [CODE_WIDTH-1:0] CODE_DEGENERATE = 3'd3;
   localparam logic [CODE_WIDTH-1:0] CODE_TOO_WIDE   = 3'd4;
   localparam logic [CODE_WIDTH-1:0] CODE_OVERFLOW   = 3'd5;

   // register indexes
   localparam logic [1:0] REG_CONE_RADIUS  = 2'd0;
   localparam logic [1:0] REG_SLICE_RADIUS = 2'd1;
   localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;

   // atan(2^-i) in units of pi/32768
   function automatic logic [13:0] atan_entry(input int i);
      logic [13:0] v;
      case (i)
         0:       v = 14'd8192;
         1:       v = 14'd4836;
         2:       v = 14'd2555;
         3:       v = 14'd1297;
         4:       v = 14'd651;
         5:       v = 14'd326;
         6:       v = 14'd163;
         7:       v = 14'd81;
         8:       v = 14'd41;
         9:       v = 14'd20;
         10:      v = 14'd10;
         11:      v = 14'd5;
         12:      v = 14'd3;
         13:      v = 14'd1;
         14:      v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/cone_center_from_closest_point.sv
// cone center from closest point: top level with checks, scaling and output register
// depends on ccfcp_pkg, ccfcp_isqrt, ccfcp_divider, ccfcp_cordic
// throughput: one beat per cycle while the pipeline advances; it advances whenever the
// output register is empty or its beat is taken, so rsp_tready low stalls every stage
// reset clears all valid bits and loads the register reset values

module cone_center_from_closest_point import ccfcp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cluster_valid, beam count[11], width[17], max_extent[17], closest_x, closest_y,
   // closest_range, zero padded to bytes
   input  logic [((46 + 3*COORD_WIDTH + 7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // candidate_valid, reject_code[3], center_x, center_y, center_range,
   // center_angle[16], zero padded to bytes
   output logic [((20 + 3*COORD_WIDTH + 7)/8)*8-1:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CW  = COORD_WIDTH;
   localparam int SQW = 2 * CW;           // x*x + y*y
   localparam int NW  = CW + 1;           // rounded norm
   localparam int PW  = CW + NW + 1;      // |c| * (n + slice)
   localparam int ODW = (20 + 3*CW + 7)/8*8;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic                  sx;
      logic                  sy;
   } ctl_type;

   // ---------------- configuration registers
   logic [15:0] cone_radius_ff, slice_radius_ff;
   logic [16:0] max_width_ff;
   logic        cfg_wr;
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         cone_radius_ff  <= CONE_RADIUS_RESET;
         slice_radius_ff <= SLICE_RADIUS_RESET;
         max_width_ff    <= MAX_WIDTH_RESET;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_CONE_RADIUS:  cone_radius_ff  <= csr_pwdata[15:0];
            REG_SLICE_RADIUS: slice_radius_ff <= csr_pwdata[15:0];
            REG_MAX_WIDTH:    max_width_ff    <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[3:2])
         REG_CONE_RADIUS:  csr_prdata = {16'd0, cone_radius_ff};
         REG_SLICE_RADIUS: csr_prdata = {16'd0, slice_radius_ff};
         REG_MAX_WIDTH:    csr_prdata = {15'd0, max_width_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- global advance
   logic out_v_ff, adv;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- input field unpack
   logic        in_cv;
   logic [10:0] in_pc;
   logic [16:0] in_w, in_e;
   logic signed [CW-1:0] in_x, in_y, in_rg;
   assign in_cv = req_tdata[0];
   assign in_pc = req_tdata[11:1];
   assign in_w  = req_tdata[28:12];
   assign in_e  = req_tdata[45:29];
   assign in_x  = req_tdata[46 +: CW];
   assign in_y  = req_tdata[46+CW +: CW];
   assign in_rg = req_tdata[46+2*CW +: CW];

   // stage a: checks and squares
   logic                  a_v_ff;
   logic [CODE_WIDTH-1:0] a_code_ff;
   logic signed [CW-1:0]  a_x_ff, a_y_ff;
   logic [SQW-1:0]        a_xx_ff, a_yy_ff;
   logic [CODE_WIDTH-1:0] code_in;
   logic [16:0]           ext;
   always_comb begin
      ext = (in_w > in_e) ? in_w : in_e;
      if (cone_radius_ff == '0 || max_width_ff == '0)      code_in = CODE_OPTIONS;
      else if (!in_cv || in_pc == '0)                      code_in = CODE_GEOMETRY;
      else if (in_rg <= 0 || (in_x == 0 && in_y == 0))     code_in = CODE_DEGENERATE;
      else if (ext > max_width_ff)                         code_in = CODE_TOO_WIDE;
      else                                                 code_in = CODE_NONE;
   end
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= req_tvalid;
      if (adv) begin
         a_code_ff <= code_in;
         a_x_ff    <= in_x;
         a_y_ff    <= in_y;
         a_xx_ff   <= SQW'($signed(in_x) * $signed(in_x));
         a_yy_ff   <= SQW'($signed(in_y) * $signed(in_y));
      end
   end

   // norm square root; tag carries code, x, y
   localparam int T1 = CODE_WIDTH + 2*CW;
   logic           n_v;
   logic [SQW/2:0] n_root;
   logic [T1-1:0]  n_tag;
   logic [SQW:0]   a_sum;
   assign a_sum = {1'b0, a_xx_ff} + {1'b0, a_yy_ff};
   ccfcp_isqrt #(.IN_WIDTH(SQW+1), .TAG_WIDTH(T1)) u_norm (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(a_v_ff),
      .in_value(a_sum), .in_tag({a_code_ff, a_x_ff, a_y_ff}),
      .out_valid(n_v), .out_root(n_root), .out_tag(n_tag));

   // stage b: products |c| * (n + slice)
   logic                  b_v_ff;
   logic [CODE_WIDTH-1:0] b_code_ff;
   logic                  b_sx_ff, b_sy_ff;
   logic [PW-1:0]         b_px_ff, b_py_ff;
   logic [NW-1:0]         b_n_ff;
   logic signed [CW-1:0]  n_x, n_y;
   logic [CW:0]           ax, ay;
   logic [NW:0]           rr;
   assign n_x = n_tag[2*CW-1:CW];
   assign n_y = n_tag[CW-1:0];
   // magnitude one bit wider so the most negative value stays exact
   assign ax  = n_x[CW-1] ? (CW+1)'(-{n_x[CW-1], n_x}) : {1'b0, n_x};
   assign ay  = n_y[CW-1] ? (CW+1)'(-{n_y[CW-1], n_y}) : {1'b0, n_y};
   assign rr  = (NW+1)'(n_root) + (NW+1)'(slice_radius_ff);
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= n_v;
      if (adv) begin
         b_code_ff <= n_tag[T1-1 -: CODE_WIDTH];
         b_sx_ff   <= n_x[CW-1];
         b_sy_ff   <= n_y[CW-1];
         b_px_ff   <= PW'(ax * rr);
         b_py_ff   <= PW'(ay * rr);
         b_n_ff    <= NW'(n_root);
      end
   end

   // two dividers in parallel; y carries its data on the x tag
   localparam int T2 = $bits(ctl_type);
   logic          dx_v, dy_v;
   logic [PW-1:0] qx, qy;
   logic [NW-1:0] rx, ry, dnx, dny;
   logic [T2-1:0] dx_tag, dy_tag;
   ctl_type       b_ctl;
   assign b_ctl = '{code: b_code_ff, sx: b_sx_ff, sy: b_sy_ff};
   logic [NW-1:0] b_den;
   assign b_den = (b_n_ff == '0) ? NW'(1) : b_n_ff;
   ccfcp_divider #(.NUM_WIDTH(PW), .DEN_WIDTH(NW), .TAG_WIDTH(T2)) u_divx (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(b_v_ff), .in_num(b_px_ff),
      .in_den(b_den), .in_tag(b_ctl), .out_valid(dx_v), .out_quot(qx), .out_rem(rx),
      .out_den(dnx), .out_tag(dx_tag));
   ccfcp_divider #(.NUM_WIDTH(PW), .DEN_WIDTH(NW), .TAG_WIDTH(T2)) u_divy (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(b_v_ff), .in_num(b_py_ff),
      .in_den(b_den), .in_tag(b_ctl), .out_valid(dy_v), .out_quot(qy), .out_rem(ry),
      .out_den(dny), .out_tag(dy_tag));

   // stage c: round and saturate
   localparam logic [PW:0] MAXNEG = (PW+1)'(64'd1 << (CW-1));
   localparam logic [PW:0] MAXPOS = MAXNEG - (PW+1)'(1);
   ctl_type               d_ctl;
   logic [PW:0]           qxr, qyr;
   logic signed [CW-1:0]  cx_in, cy_in;
   logic                  ovf_in;
   logic                  c_v_ff, c_ovf_ff;
   logic [CODE_WIDTH-1:0] c_code_ff;
   logic signed [CW-1:0]  c_x_ff, c_y_ff;
   logic [SQW-1:0]        c_xx_ff, c_yy_ff;
   assign d_ctl = ctl_type'(dx_tag);
   always_comb begin
      qxr = {1'b0, qx} + (PW+1)'(({1'b0, rx} << 1) >= {1'b0, dnx});
      qyr = {1'b0, qy} + (PW+1)'(({1'b0, ry} << 1) >= {1'b0, dny});
      ovf_in = 1'b0;
      if (!d_ctl.sx) begin
         if (qxr > MAXPOS) begin qxr = MAXPOS; ovf_in = 1'b1; end
         cx_in = CW'(qxr);
      end else begin
         if (qxr > MAXNEG) begin qxr = MAXNEG; ovf_in = 1'b1; end
         cx_in = CW'(-qxr);
      end
      if (!d_ctl.sy) begin
         if (qyr > MAXPOS) begin qyr = MAXPOS; ovf_in = 1'b1; end
         cy_in = CW'(qyr);
      end else begin
         if (qyr > MAXNEG) begin qyr = MAXNEG; ovf_in = 1'b1; end
         cy_in = CW'(-qyr);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= dx_v;
      if (adv) begin
         c_code_ff <= d_ctl.code;
         c_ovf_ff  <= ovf_in;
         c_x_ff    <= cx_in;
         c_y_ff    <= cy_in;
         c_xx_ff   <= SQW'(cx_in * cx_in);
         c_yy_ff   <= SQW'(cy_in * cy_in);
      end
   end

   // center range root and bearing cordic, aligned to the same latency
   localparam int SQL = (SQW + 2) / 2 + 1;
   localparam int T3  = CODE_WIDTH + 1 + 2*CW;
   logic [SQW:0]   c_sum;
   logic           r_v;
   logic [SQW/2:0] r_root;
   logic [T3-1:0]  r_tag;
   assign c_sum = {1'b0, c_xx_ff} + {1'b0, c_yy_ff};
   ccfcp_isqrt #(.IN_WIDTH(SQW+1), .TAG_WIDTH(T3)) u_range (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(c_v_ff), .in_value(c_sum),
      .in_tag({c_code_ff, c_ovf_ff, c_x_ff, c_y_ff}),
      .out_valid(r_v), .out_root(r_root), .out_tag(r_tag));

   // delay line so the cordic input lines up with the range output
   localparam int CDL = (SQL > CORDIC_STAGES + 1) ? SQL - CORDIC_STAGES - 1 : 0;
   localparam int RDL = (CORDIC_STAGES + 1 > SQL) ? CORDIC_STAGES + 1 - SQL : 0;
   logic signed [CW-1:0] cd_x_ff [CDL+1];
   logic signed [CW-1:0] cd_y_ff [CDL+1];
   logic                 cd_v_ff [CDL+1];
   assign cd_x_ff[0] = c_x_ff;
   assign cd_y_ff[0] = c_y_ff;
   assign cd_v_ff[0] = c_v_ff;
   for (genvar k = 0; k < CDL; k++) begin : g_cdl
      always_ff @(posedge clock) begin
         if (reset) cd_v_ff[k+1] <= 1'b0;
         else if (adv) cd_v_ff[k+1] <= cd_v_ff[k];
         if (adv) begin
            cd_x_ff[k+1] <= cd_x_ff[k];
            cd_y_ff[k+1] <= cd_y_ff[k];
         end
      end
   end
   logic                   g_v;
   logic [ANGLE_WIDTH-1:0] g_ang;
   logic                   g_tag;
   ccfcp_cordic #(.COORD_WIDTH(CW), .CORDIC_STAGES(CORDIC_STAGES), .TAG_WIDTH(1)) u_cordic (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(cd_v_ff[CDL]),
      .in_x(cd_x_ff[CDL]), .in_y(cd_y_ff[CDL]), .in_tag(1'b0),
      .out_valid(g_v), .out_angle(g_ang), .out_tag(g_tag));

   logic [SQW/2:0] rd_root_ff [RDL+1];
   logic [T3-1:0]  rd_tag_ff  [RDL+1];
   logic           rd_v_ff    [RDL+1];
   assign rd_root_ff[0] = r_root;
   assign rd_tag_ff[0]  = r_tag;
   assign rd_v_ff[0]    = r_v;
   for (genvar k = 0; k < RDL; k++) begin : g_rdl
      always_ff @(posedge clock) begin
         if (reset) rd_v_ff[k+1] <= 1'b0;
         else if (adv) rd_v_ff[k+1] <= rd_v_ff[k];
         if (adv) begin
            rd_root_ff[k+1] <= rd_root_ff[k];
            rd_tag_ff[k+1]  <= rd_tag_ff[k];
         end
      end
   end

   // output register
   logic [ODW-1:0]        out_d_ff, out_d_in;
   logic [T3-1:0]         f_tag;
   logic [CODE_WIDTH-1:0] f_code;
   logic                  f_ovf;
   assign f_tag  = rd_tag_ff[RDL];
   assign f_code = f_tag[T3-1 -: CODE_WIDTH];
   assign f_ovf  = f_tag[2*CW];
   always_comb begin
      out_d_in = '0;
      if (f_code != CODE_NONE) begin
         out_d_in[3:1] = f_code;
      end else begin
         out_d_in[0]              = !f_ovf && !g_tag;
         out_d_in[3:1]            = f_ovf ? CODE_OVERFLOW : CODE_NONE;
         out_d_in[4 +: CW]        = f_tag[2*CW-1:CW];
         out_d_in[4+CW +: CW]     = f_tag[CW-1:0];
         out_d_in[4+2*CW +: CW]   = CW'(rd_root_ff[RDL]);
         out_d_in[4+3*CW +: ANGLE_WIDTH] = g_ang;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= rd_v_ff[RDL] && g_v;
      if (adv) out_d_ff <= out_d_in;
   end
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   // the range and bearing paths stay aligned
   a_align: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff[RDL] == g_v) else $error("range and bearing misaligned");
   // a stalled output beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output beat changed under stall");
   // a rejected beat carries no candidate
   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:1] != CODE_NONE |-> !rsp_tdata[0])
      else $error("candidate on rejected beat");
   // both dividers move together
   a_div: assert property (@(posedge clock) disable iff (reset)
      dx_v == dy_v && dx_tag == dy_tag) else $error("divider lanes out of step");
endmodule

>>> hw/rtl/ccfcp_isqrt.sv
// pipelined rounded integer square root, one result bit per stage
// depends on ccfcp_pkg

module ccfcp_isqrt import ccfcp_pkg::*; #(
   parameter int IN_WIDTH = 34,
   parameter int TAG_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [IN_WIDTH-1:0]    in_value,
   input  logic [TAG_WIDTH-1:0]   in_tag,
   output logic                   out_valid,
   output logic [IN_WIDTH/2:0]    out_root,
   output logic [TAG_WIDTH-1:0]   out_tag
);
   localparam int HALF = (IN_WIDTH + 1) / 2;
   localparam int RW   = 2 * HALF;
   localparam int QW   = HALF + 1;

   logic [RW+1:0]      rem_ff  [HALF+1];
   logic [QW-1:0]      root_ff [HALF+1];
   logic [RW-1:0]      val_ff  [HALF+1];
   logic [TAG_WIDTH-1:0] tag_ff [HALF+1];
   logic               v_ff    [HALF+1];

   // stage 0 takes the operand
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         val_ff[0]  <= RW'(in_value);
         tag_ff[0]  <= in_tag;
      end
   end

   // restoring digit recurrence, two radicand bits per stage
   for (genvar s = 0; s < HALF; s++) begin : g_stage
      logic [RW+1:0] rem_in;
      logic [RW+1:0] trial;
      logic [QW-1:0] root_in;
      always_comb begin
         rem_in = {rem_ff[s][RW-1:0], val_ff[s][RW-1:RW-2]};
         trial  = (RW+2)'({root_ff[s], 2'b01});
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_ff[s][QW-2:0], 1'b1};
         end else begin
            root_in = {root_ff[s][QW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            v_ff[s+1] <= v_ff[s];
         end
         if (adv) begin
            rem_ff[s+1]  <= rem_in;
            root_ff[s+1] <= root_in;
            val_ff[s+1]  <= {val_ff[s][RW-3:0], 2'b00};
            tag_ff[s+1]  <= tag_ff[s];
         end
      end
   end

   // round half up: remainder above root means n > r*r + r
   logic [QW-1:0] rounded;
   always_comb begin
      rounded = root_ff[HALF];
      if (rem_ff[HALF] > (RW+2)'(root_ff[HALF])) rounded = rounded + 1'b1;
   end
   assign out_valid = v_ff[HALF];
   assign out_root  = (IN_WIDTH/2+1)'(rounded);
   assign out_tag   = tag_ff[HALF];
endmodule

>>> hw/rtl/ccfcp_divider.sv
// pipelined unsigned restoring divider, one quotient bit per stage, with remainder
// depends on ccfcp_pkg

module ccfcp_divider import ccfcp_pkg::*; #(
   parameter int NUM_WIDTH = 34,
   parameter int DEN_WIDTH = 17,
   parameter int TAG_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [NUM_WIDTH-1:0]   in_num,
   input  logic [DEN_WIDTH-1:0]   in_den,
   input  logic [TAG_WIDTH-1:0]   in_tag,
   output logic                   out_valid,
   output logic [NUM_WIDTH-1:0]   out_quot,
   output logic [DEN_WIDTH-1:0]   out_rem,
   output logic [DEN_WIDTH-1:0]   out_den,
   output logic [TAG_WIDTH-1:0]   out_tag
);
   logic [DEN_WIDTH-1:0] rem_ff [NUM_WIDTH+1];
   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH+1];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH+1];
   logic [TAG_WIDTH-1:0] tag_ff [NUM_WIDTH+1];
   logic                 v_ff   [NUM_WIDTH+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0] <= '0;
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
      end
   end

   // numerator bits shift out at the top, quotient bits shift in at the bottom
   for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
      logic [DEN_WIDTH:0]   part;
      logic [DEN_WIDTH-1:0] rem_in;
      logic                 qbit;
      always_comb begin
         part = {rem_ff[s], num_ff[s][NUM_WIDTH-1]};
         qbit = (part >= {1'b0, den_ff[s]});
         if (qbit) part = part - {1'b0, den_ff[s]};
         rem_in = part[DEN_WIDTH-1:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            v_ff[s+1] <= v_ff[s];
         end
         if (adv) begin
            rem_ff[s+1] <= rem_in;
            num_ff[s+1] <= {num_ff[s][NUM_WIDTH-2:0], qbit};
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = v_ff[NUM_WIDTH];
   assign out_quot  = num_ff[NUM_WIDTH];
   assign out_rem   = rem_ff[NUM_WIDTH];
   assign out_den   = den_ff[NUM_WIDTH];
   assign out_tag   = tag_ff[NUM_WIDTH];
endmodule

>>> hw/rtl/ccfcp_cordic.sv
// unrolled cordic vectoring pipeline giving the bearing of a point
// depends on ccfcp_pkg

module ccfcp_cordic import ccfcp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int TAG_WIDTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic [TAG_WIDTH-1:0]          in_tag,
   output logic                          out_valid,
   output logic [ANGLE_WIDTH-1:0]        out_angle,
   output logic [TAG_WIDTH-1:0]          out_tag
);
   // gain below 1.65 plus the quarter turn: three guard bits suffice
   localparam int XW = COORD_WIDTH + 3;

   logic signed [XW-1:0]     x_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0]     y_ff [CORDIC_STAGES+1];
   logic [ANGLE_WIDTH-1:0]   z_ff [CORDIC_STAGES+1];
   logic [TAG_WIDTH-1:0]     t_ff [CORDIC_STAGES+1];
   logic                     v_ff [CORDIC_STAGES+1];

   // quarter-turn pre-rotation for the left half-plane
   logic signed [XW-1:0]   x0, y0, xe, ye;
   logic [ANGLE_WIDTH-1:0] z0;
   always_comb begin
      xe = XW'(in_x);
      ye = XW'(in_y);
      x0 = xe;
      y0 = ye;
      z0 = '0;
      if (xe < 0) begin
         if (ye >= 0) begin
            x0 = ye;
            y0 = -xe;
            z0 = ANGLE_WIDTH'(16384);
         end else begin
            x0 = -ye;
            y0 = xe;
            z0 = ANGLE_WIDTH'(-16384);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0] <= x0;
         y_ff[0] <= y0;
         z_ff[0] <= z0;
         t_ff[0] <= in_tag;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [XW-1:0]   x_in, y_in;
      logic [ANGLE_WIDTH-1:0] z_in;
      always_comb begin
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ANGLE_WIDTH'(atan_entry(i));
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ANGLE_WIDTH'(atan_entry(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (adv) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            t_ff[i+1] <= t_ff[i];
         end
      end
   end

   assign out_valid = v_ff[CORDIC_STAGES];
   assign out_angle = z_ff[CORDIC_STAGES];
   assign out_tag   = t_ff[CORDIC_STAGES];
endmodule

>>> bench/testbench.sv
// self-checking bench for cone_center_from_closest_point: apb register setup,
// cluster beats with random gaps, results checked against an in-bench predictor
// depends on ccfcp_pkg and the block rtl

module testbench;
   import ccfcp_pkg::*;

   localparam int CW = 17;
   localparam int REQ_W = ((46 + 3*CW + 7)/8)*8;
   localparam int RSP_W = ((20 + 3*CW + 7)/8)*8;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [15:0] angle;
      logic [16:0] range;
      logic [16:0] cy;
      logic [16:0] cx;
      logic [2:0]  code;
      logic        cand;
   } cone_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor copy of the registers
   logic [15:0] cone_radius_q = CONE_RADIUS_RESET;
   logic [15:0] slice_q = SLICE_RADIUS_RESET;
   logic [16:0] max_width_q = MAX_WIDTH_RESET;

   int accepted = 0, results_seen = 0, idle_cycles = 0;
   bit hold_long = 0;
   int code_hits [0:5];

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   cone_center_from_closest_point dut (.*);

   function automatic longint unsigned root_round(input longint unsigned v);
      longint unsigned r, b, n;
      n = v; r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      if (n > r) r++;
      return r;
   endfunction

   function automatic longint push_out(input longint c, input longint unsigned rr,
                                       input longint unsigned n, inout bit sat);
      longint unsigned a, p, q;
      a = c < 0 ? -c : c;
      p = a * rr; q = p / n;
      if (2 * (p % n) >= n) q++;
      if (c >= 0) begin
         if (q > 65535) begin q = 65535; sat = 1; end
         return q;
      end
      if (q > 65536) begin q = 65536; sat = 1; end
      return -longint'(q);
   endfunction

   function automatic longint fshift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint bearing(input longint x0, input longint y0);
      longint x, y, z, t, dx, dy;
      int tab [0:15] = '{8192,4836,2555,1297,651,326,163,81,41,20,10,5,3,1,1,0};
      x = x0; y = y0; z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin x = y; y = -t; z = 16384; end
         else begin x = -y; y = t; z = -16384; end
      end
      for (int i = 0; i < 16; i++) begin
         dx = fshift(y, i); dy = fshift(x, i);
         if (y > 0) begin x += dx; y -= dy; z += tab[i]; end
         else begin x -= dx; y += dy; z -= tab[i]; end
      end
      return z;
   endfunction

   function automatic cone_type cone_of(input logic [REQ_W-1:0] d);
      cone_type o;
      logic [16:0] w, e;
      longint x, y, rg, cx, cy;
      longint unsigned n, rr;
      bit sat;
      o = '0; sat = 0;
      w = d[28:12]; e = d[45:29];
      x = $signed(d[62:46]); y = $signed(d[79:63]); rg = $signed(d[96:80]);
      if (cone_radius_q == 0 || max_width_q == 0) o.code = CODE_OPTIONS;
      else if (!d[0] || d[11:1] == 0) o.code = CODE_GEOMETRY;
      else if (rg <= 0 || (x == 0 && y == 0)) o.code = CODE_DEGENERATE;
      else if ((w > e ? w : e) > max_width_q) o.code = CODE_TOO_WIDE;
      if (o.code != CODE_NONE) return o;
      n = root_round(x*x + y*y);
      rr = n + slice_q;
      cx = push_out(x, rr, n, sat);
      cy = push_out(y, rr, n, sat);
      o.cand = !sat;
      o.code = sat ? CODE_OVERFLOW : CODE_NONE;
      o.cx = 17'(cx); o.cy = 17'(cy);
      o.range = 17'(root_round(cx*cx + cy*cy));
      o.angle = 16'(bearing(cx, cy));
      return o;
   endfunction

   class cone_scoreboard;
      cone_type pending [$];
      int errors = 0;
      function void note_cluster(cone_type c);
         pending = {pending, c};
      endfunction
      function void check_cone(cone_type got);
         cone_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.cand !== want.cand || got.code !== want.code || got.cx !== want.cx ||
             got.cy !== want.cy || got.range !== want.range || got.angle !== want.angle) begin
            $display("%0t mismatch exp v%0d c%0d x%0d y%0d r%0d a%0d", $time, want.cand,
                     want.code, $signed(want.cx), $signed(want.cy), want.range,
                     $signed(want.angle));
            $display("%0t          got v%0d c%0d x%0d y%0d r%0d a%0d", $time, got.cand,
                     got.code, $signed(got.cx), $signed(got.cy), got.range,
                     $signed(got.angle));
            errors++;
         end
      endfunction
   endclass

   cone_scoreboard sb = new();

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // result side: check beats, random stalls, one long hold
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         cone_type got;
         got = rsp_tdata[$bits(cone_type)-1:0];
         code_hits[got.code]++;
         results_seen++;
         sb.check_cone(got);
      end
   end

   initial begin
      int g;
      @(posedge clock);
      while (1) begin
         if (hold_long) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_long = 0;
         end
         g = (accepted < 300) ? 0 : gap_len();
         rsp_tready <= (g == 0);
         @(posedge clock);
         if (g > 1) repeat (g - 1) @(posedge clock);
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAIL cone_center_from_closest_point");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_CONE_RADIUS:  cone_radius_q = val[15:0];
         REG_SLICE_RADIUS: slice_q = val[15:0];
         default:          max_width_q = val[16:0];
      endcase
   endtask

   task automatic send_cluster(input logic [REQ_W-1:0] d, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_cluster(cone_of(d));
      accepted++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [REQ_W-1:0] pack(input bit v, input logic [10:0] pc,
      input logic [16:0] w, input logic [16:0] e, input logic [16:0] x,
      input logic [16:0] y, input logic [16:0] r);
      logic [REQ_W-1:0] d;
      d = '0;
      d[0] = v; d[11:1] = pc; d[28:12] = w; d[45:29] = e;
      d[62:46] = x; d[79:63] = y; d[96:80] = r;
      return d;
   endfunction

   function automatic logic [16:0] rnd_coord();
      case ($urandom_range(0, 4))
         0: return 17'($urandom_range(0, 131071));
         1: return 17'($urandom_range(0, 600));
         2: return 17'(-$urandom_range(1, 600));
         3: return 17'($urandom_range(60000, 65535));
         default: return 17'(-$urandom_range(60000, 65536));
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] rnd_cluster();
      logic [10:0] pc;
      logic [16:0] w, e, r;
      bit v;
      int p;
      p = $urandom_range(0, 99);
      v = (p < 95) ? 1'b1 : 1'($urandom_range(0, 1));
      pc = (p > 2) ? 11'($urandom_range(1, 2047)) : 11'($urandom_range(0, 2047));
      w = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, max_width_q)) :
          17'($urandom_range(0, 131071));
      e = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, max_width_q)) :
          17'($urandom_range(0, 131071));
      r = ($urandom_range(0, 19) != 0) ? 17'($urandom_range(1, 65535)) :
          17'($urandom_range(0, 131071));
      return pack(v, pc, w, e, rnd_coord(), rnd_coord(), r);
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) send_cluster(rnd_cluster(), 1);
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: the geometry, degenerate, too wide and overflow reject paths, extremes, three quadrants and the axes
      send_cluster(pack(1, 5, 10, 10, 17'd1000, 17'd0, 17'd1000), 0);
      send_cluster(pack(0, 5, 10, 10, 17'd1000, 17'd0, 17'd1000), 0);
      send_cluster(pack(1, 0, 10, 10, 17'd1000, 17'd0, 17'd1000), 0);
      send_cluster(pack(1, 2047, 0, 0, 17'd0, 17'd0, 17'd100), 0);
      send_cluster(pack(1, 5, 0, 0, 17'd100, 17'd100, 17'd0), 0);
      send_cluster(pack(1, 5, 0, 0, 17'd100, 17'd100, -17'd1), 0);
      send_cluster(pack(1, 5, 513, 0, 17'd100, 17'd100, 17'd100), 0);
      send_cluster(pack(1, 5, 0, 17'h1ffff, 17'd100, 17'd100, 17'd100), 0);
      send_cluster(pack(1, 5, 512, 512, -17'd1000, 17'd0, 17'd1000), 0);
      send_cluster(pack(1, 5, 0, 0, -17'd1000, 17'd1, 17'd1000), 0);
      send_cluster(pack(1, 5, 0, 0, -17'd1000, -17'd1, 17'd1000), 0);
      send_cluster(pack(1, 5, 0, 0, 17'd0, -17'd700, 17'd700), 0);
      send_cluster(pack(1, 5, 0, 0, 17'd0, 17'd700, 17'd700), 0);
      send_cluster(pack(1, 5, 0, 0, 17'd65535, 17'd65535, 17'd65535), 0);
      send_cluster(pack(1, 5, 0, 0, -17'd65536, -17'd65536, 17'd65535), 0);
      send_cluster(pack(1, 5, 0, 0, -17'd65536, 17'd0, 17'd65535), 0);
      send_cluster(pack(1, 5, 0, 0, 17'd1, 17'd1, 17'd1), 0);
      send_cluster(pack(1, 5, 0, 0, -17'd1, 17'd0, 17'd1), 0);
      drain();

      // long receiver hold while clusters keep arriving
      hold_long = 1;
      random_phase(500);

      csr_write(REG_CONE_RADIUS, 0);
      random_phase(40);
      csr_write(REG_CONE_RADIUS, 32'hffff);
      csr_write(REG_MAX_WIDTH, 0);
      random_phase(40);
      csr_write(REG_MAX_WIDTH, 32'h1ffff);
      csr_write(REG_SLICE_RADIUS, 0);
      random_phase(300);
      csr_write(REG_SLICE_RADIUS, 32'hffff);
      random_phase(300);
      csr_write(REG_CONE_RADIUS, 1);
      csr_write(REG_SLICE_RADIUS, $urandom_range(0, 4000));
      csr_write(REG_MAX_WIDTH, $urandom_range(1, 20000));
      random_phase(650);

      $display("covered %0d clusters, %0d results; codes none %0d options %0d geometry %0d",
               accepted, results_seen, code_hits[0], code_hits[1], code_hits[2]);
      $display("degenerate %0d too wide %0d overflow %0d over six register settings",
               code_hits[3], code_hits[4], code_hits[5]);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS cone_center_from_closest_point");
      else
         $display("FAIL cone_center_from_closest_point");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ccfcp_pkg.sv
hw/rtl/ccfcp_isqrt.sv
hw/rtl/ccfcp_divider.sv
hw/rtl/ccfcp_cordic.sv
hw/rtl/cone_center_from_closest_point.sv
bench/testbench.sv
